@@ rtl/core/mbsc_pkg.sv @@
// Package for the masked brush stamp clipper: sizes, codes and item structs.
// Used by mbsc_alu and the top level; depends on nothing.
`default_nettype none

package mbsc_pkg;

    localparam int MAX_BRUSH       = 16;
    localparam int CHUNK_SIZE      = 16;
    localparam int MAX_CANVAS      = 1024;
    localparam int CHUNK_SHIFT     = $clog2(CHUNK_SIZE);
    localparam int MASK_ROWS       = 16;
    localparam int MASK_W          = 16;
    localparam int MASK_ROW_W      = $clog2(MASK_ROWS);

    localparam int CHUNKS_PER_SIDE = (MAX_CANVAS + CHUNK_SIZE - 1) / CHUNK_SIZE;
    localparam int DIRTY_DEPTH     = CHUNKS_PER_SIDE * CHUNKS_PER_SIDE;
    localparam int DIRTY_WORD_W    = 64;
    localparam int DIRTY_WORDS     = DIRTY_DEPTH / DIRTY_WORD_W;
    localparam int DIRTY_ADDR_W    = $clog2(DIRTY_WORDS);
    localparam int DIRTY_BIT_W     = $clog2(DIRTY_WORD_W);
    localparam int IDX_W           = $clog2(DIRTY_DEPTH);

    localparam int ALU_W           = 14;
    localparam int CHK_W           = ALU_W - CHUNK_SHIFT;
    localparam int CNT_CHUNK_W     = 7;
    localparam int CHUNK_COORD_W   = 6;

    localparam int CNV_W           = 11;
    localparam int BRUSH_W         = 5;
    localparam int LCNT_W          = 5;
    localparam int COORD_W         = 10;

    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BRUSH_WIDTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BRUSH_HEIGHT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LAYER_COUNT   = 3'd4;

    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_PLACE = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    localparam logic [1:0] KIND_UNDO = 2'd0;
    localparam logic [1:0] KIND_ROW  = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [3:0]         mask_row;
        logic [15:0]        mask_bits;
        logic signed [11:0] pos_x;
        logic signed [11:0] pos_y;
        logic [3:0]         layer_index;
        logic               layer_is_bump;
        logic [7:0]         paint_color;
    } request_t;

    typedef struct packed {
        logic [1:0]  item_kind;
        logic [5:0]  chunk_col;
        logic [5:0]  chunk_row;
        logic [3:0]  layer_out;
        logic [9:0]  row_y;
        logic [9:0]  col_start;
        logic [15:0] pixel_mask;
        logic [7:0]  color_out;
        logic        refresh;
        logic        drawn;
        logic        last;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/core/mbsc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
`default_nettype none

module mbsc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ rtl/core/mbsc_alu.sv @@
// Shared signed add/subtract unit stepped by the stamp sequencer.
// Depends on mbsc_pkg for the datapath width.
`default_nettype none

module mbsc_alu (
    input  wire logic signed [mbsc_pkg::ALU_W-1:0] a,
    input  wire logic signed [mbsc_pkg::ALU_W-1:0] b,
    input  wire logic                              sub,
    output logic signed      [mbsc_pkg::ALU_W-1:0] sum
);

    always_comb
    begin
        if (sub)
        begin
            sum = a - b;
        end
        else
        begin
            sum = a + b;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/masked_brush_stamp_clipper_unit.sv @@
// Top level of the masked brush stamp clipper: sequencer, config, mask and dirty map.
// Depends on mbsc_pkg, mbsc_alu and mbsc_ram.
//
// A mask load is written while idle and never raises busy. A place request runs
// its setup steps through the one shared adder; when undo_en is set it then
// tests each covered chunk and checks those on the canvas (dirty map read, then
// update). It sends one item per clipped row and then the done item, all with
// busy high; each result is registered and shows in the cycle after the cycle
// that makes it. A clear request, and reset, sweep the 64-word dirty map memory
// one word a cycle with busy high. Results come as one-cycle strobes and cannot be
// held off; config writes are always ready and belong in idle time.
`default_nettype none

module masked_brush_stamp_clipper_unit (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire mbsc_pkg::request_t                    request,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [mbsc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [mbsc_pkg::CFG_DATA_W-1:0]       cfg_data,
    output logic                                       result_strobe,
    output mbsc_pkg::result_t                          result
);

    localparam logic [2:0] ST_CLEAR    = 3'd0;
    localparam logic [2:0] ST_IDLE     = 3'd1;
    localparam logic [2:0] ST_SETUP    = 3'd2;
    localparam logic [2:0] ST_CK_TEST  = 3'd3;
    localparam logic [2:0] ST_CK_CHECK = 3'd4;
    localparam logic [2:0] ST_ROW      = 3'd5;
    localparam logic [2:0] ST_DONE     = 3'd6;

    localparam logic [3:0] SU_X   = 4'd0;
    localparam logic [3:0] SU_Y   = 4'd1;
    localparam logic [3:0] SU_XE  = 4'd2;
    localparam logic [3:0] SU_YE  = 4'd3;
    localparam logic [3:0] SU_CS  = 4'd4;
    localparam logic [3:0] SU_CE  = 4'd5;
    localparam logic [3:0] SU_RS  = 4'd6;
    localparam logic [3:0] SU_RE  = 4'd7;
    localparam logic [3:0] SU_SX  = 4'd8;
    localparam logic [3:0] SU_SY  = 4'd9;
    localparam logic [3:0] SU_X1  = 4'd10;
    localparam logic [3:0] SU_Y1  = 4'd11;
    localparam logic [3:0] SU_NC  = 4'd12;
    localparam logic [3:0] SU_NR  = 4'd13;

    localparam int AW  = mbsc_pkg::ALU_W;
    localparam int KW  = mbsc_pkg::CHK_W;
    localparam int DW  = mbsc_pkg::DIRTY_WORD_W;
    localparam int DAW = mbsc_pkg::DIRTY_ADDR_W;
    localparam int DBW = mbsc_pkg::DIRTY_BIT_W;
    localparam int IW  = mbsc_pkg::IDX_W;
    localparam int MW  = mbsc_pkg::MASK_W;
    localparam int CW  = mbsc_pkg::COORD_W;

    logic [2:0]                          state_reg, state_next;
    logic [3:0]                          step_reg, step_next;
    logic [DAW-1:0]                      clr_cnt_reg, clr_cnt_next;
    logic                                result_strobe_reg, result_strobe_next;
    mbsc_pkg::result_t                   result_reg, result_next;

    logic [mbsc_pkg::CNV_W-1:0]          canvas_w_reg, canvas_h_reg;
    logic [mbsc_pkg::BRUSH_W-1:0]        brush_w_reg, brush_h_reg;
    logic [mbsc_pkg::LCNT_W-1:0]         layer_cnt_reg;

    logic [MW-1:0]                       brush_mask_reg [mbsc_pkg::MASK_ROWS];
    mbsc_pkg::request_t                  req_reg, req_next;

    logic signed [AW-1:0]                x_reg, x_next, y_reg, y_next;
    logic signed [AW-1:0]                xe_reg, xe_next, ye_reg, ye_next;
    logic signed [AW-1:0]                x1_reg, x1_next, y1_reg, y1_next;
    logic signed [KW-1:0]                cs_reg, cs_next, ce_reg, ce_next;
    logic signed [KW-1:0]                rs_reg, rs_next, re_reg, re_next;
    logic signed [KW-1:0]                r_reg, r_next, c_reg, c_next;
    logic [3:0]                          sx_reg, sx_next, sy_reg, sy_next;
    logic [4:0]                          nc_reg, nc_next;
    logic                                nc_pos_reg, nc_pos_next;
    logic                                drawn_reg, drawn_next;
    logic [4:0]                          rows_left_reg, rows_left_next;
    logic [IW-1:0]                       idx_reg, idx_next;
    logic [CW-1:0]                       cr_reg, cr_next;
    logic [mbsc_pkg::MASK_ROW_W-1:0]     mr_reg, mr_next;

    logic signed [AW-1:0]                alu_a, alu_b, alu_sum;
    logic                                alu_sub;

    logic                                ram_we;
    logic [DAW-1:0]                      ram_waddr;
    logic [DW-1:0]                       ram_wdata, ram_rdata;

    logic                                accept;
    logic                                undo_en;
    logic [mbsc_pkg::CNT_CHUNK_W-1:0]    cols, rows;
    logic                                ck_in_range;
    logic [IW:0]                         ck_idx_full;
    logic [IW-1:0]                       ck_idx;
    logic                                ck_step;
    logic                                sum_pos;
    logic [MW-1:0]                       col_mask, row_bits;

    assign busy          = (state_reg != ST_IDLE);
    assign accept        = start && !busy;
    assign cfg_ready     = 1'b1;
    assign result_strobe = result_strobe_reg;
    assign result        = result_reg;

    assign cols = canvas_w_reg[mbsc_pkg::CNV_W-1:mbsc_pkg::CHUNK_SHIFT]
                + mbsc_pkg::CNT_CHUNK_W'(|canvas_w_reg[mbsc_pkg::CHUNK_SHIFT-1:0]);
    assign rows = canvas_h_reg[mbsc_pkg::CNV_W-1:mbsc_pkg::CHUNK_SHIFT]
                + mbsc_pkg::CNT_CHUNK_W'(|canvas_h_reg[mbsc_pkg::CHUNK_SHIFT-1:0]);

    assign undo_en = (layer_cnt_reg == '0)
                  || ({1'b0, req_reg.layer_index} != (layer_cnt_reg - 5'd1));

    assign ck_in_range = !r_reg[KW-1] && !c_reg[KW-1]
                      && (r_reg[KW-2:0] < (KW-1)'(rows))
                      && (c_reg[KW-2:0] < (KW-1)'(cols));
    assign ck_idx_full = (IW+1)'(r_reg[mbsc_pkg::CHUNK_COORD_W-1:0]) * (IW+1)'(cols)
                       + (IW+1)'(c_reg[mbsc_pkg::CHUNK_COORD_W-1:0]);
    assign ck_idx      = ck_idx_full[IW-1:0];

    assign sum_pos = !alu_sum[AW-1] && (alu_sum != '0);

    always_comb
    begin
        for (int i = 0; i < MW; i++)
        begin
            col_mask[i] = (5'(i) < nc_reg);
        end
    end

    assign row_bits = brush_mask_reg[mr_reg] >> sx_reg;

    mbsc_alu u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .sub (alu_sub),
        .sum (alu_sum)
    );

    mbsc_ram #(
        .WIDTH (DW),
        .DEPTH (mbsc_pkg::DIRTY_WORDS)
    ) u_dirty_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ck_idx[IW-1:DBW]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        unique case (step_reg)
            SU_X:
            begin
                alu_a   = AW'(req_reg.pos_x);
                alu_b   = AW'(brush_w_reg >> 1);
                alu_sub = 1'b1;
            end
            SU_Y:
            begin
                alu_a   = AW'(req_reg.pos_y);
                alu_b   = AW'(brush_h_reg >> 1);
                alu_sub = 1'b1;
            end
            SU_XE:
            begin
                alu_a = x_reg;
                alu_b = AW'(brush_w_reg);
            end
            SU_YE:
            begin
                alu_a = y_reg;
                alu_b = AW'(brush_h_reg);
            end
            SU_CS:
            begin
                alu_a = x_reg;
                alu_b = x_reg[AW-1] ? AW'(mbsc_pkg::CHUNK_SIZE - 1) : '0;
            end
            SU_CE:
            begin
                alu_a = xe_reg;
                alu_b = xe_reg[AW-1] ? AW'(mbsc_pkg::CHUNK_SIZE - 1) : '0;
            end
            SU_RS:
            begin
                alu_a = y_reg;
                alu_b = y_reg[AW-1] ? AW'(mbsc_pkg::CHUNK_SIZE - 1) : '0;
            end
            SU_RE:
            begin
                alu_a = ye_reg;
                alu_b = ye_reg[AW-1] ? AW'(mbsc_pkg::CHUNK_SIZE - 1) : '0;
            end
            SU_SX:
            begin
                alu_b   = x_reg;
                alu_sub = 1'b1;
            end
            SU_SY:
            begin
                alu_b   = y_reg;
                alu_sub = 1'b1;
            end
            SU_X1:
            begin
                alu_a   = xe_reg;
                alu_b   = AW'(canvas_w_reg);
                alu_sub = 1'b1;
            end
            SU_Y1:
            begin
                alu_a   = ye_reg;
                alu_b   = AW'(canvas_h_reg);
                alu_sub = 1'b1;
            end
            SU_NC:
            begin
                alu_a   = x1_reg;
                alu_b   = x_reg[AW-1] ? '0 : x_reg;
                alu_sub = 1'b1;
            end
            SU_NR:
            begin
                alu_a   = y1_reg;
                alu_b   = y_reg[AW-1] ? '0 : y_reg;
                alu_sub = 1'b1;
            end
            default:
            begin
                alu_a   = '0;
                alu_b   = '0;
                alu_sub = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next         = state_reg;
        step_next          = step_reg;
        clr_cnt_next       = clr_cnt_reg;
        result_strobe_next = 1'b0;
        result_next        = '0;
        req_next           = req_reg;
        x_next             = x_reg;
        y_next             = y_reg;
        xe_next            = xe_reg;
        ye_next            = ye_reg;
        x1_next            = x1_reg;
        y1_next            = y1_reg;
        cs_next            = cs_reg;
        ce_next            = ce_reg;
        rs_next            = rs_reg;
        re_next            = re_reg;
        r_next             = r_reg;
        c_next             = c_reg;
        sx_next            = sx_reg;
        sy_next            = sy_reg;
        nc_next            = nc_reg;
        nc_pos_next        = nc_pos_reg;
        drawn_next         = drawn_reg;
        rows_left_next     = rows_left_reg;
        idx_next           = idx_reg;
        cr_next            = cr_reg;
        mr_next            = mr_reg;
        ram_we             = 1'b0;
        ram_waddr          = idx_reg[IW-1:DBW];
        ram_wdata          = ram_rdata | (DW'(1) << idx_reg[DBW-1:0]);
        ck_step            = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    req_next = request;
                    unique case (request.req_type)
                        mbsc_pkg::REQ_PLACE:
                        begin
                            state_next = ST_SETUP;
                            step_next  = SU_X;
                        end
                        mbsc_pkg::REQ_CLEAR:
                        begin
                            state_next   = ST_CLEAR;
                            clr_cnt_next = '0;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SETUP:
            begin
                step_next = step_reg + 1'b1;
                unique case (step_reg)
                    SU_X:  x_next  = alu_sum;
                    SU_Y:  y_next  = alu_sum;
                    SU_XE: xe_next = alu_sum;
                    SU_YE: ye_next = alu_sum;
                    SU_CS: cs_next = alu_sum[AW-1:mbsc_pkg::CHUNK_SHIFT];
                    SU_CE: ce_next = alu_sum[AW-1:mbsc_pkg::CHUNK_SHIFT];
                    SU_RS: rs_next = alu_sum[AW-1:mbsc_pkg::CHUNK_SHIFT];
                    SU_RE: re_next = alu_sum[AW-1:mbsc_pkg::CHUNK_SHIFT];
                    SU_SX: sx_next = x_reg[AW-1] ? alu_sum[3:0] : 4'd0;
                    SU_SY: sy_next = y_reg[AW-1] ? alu_sum[3:0] : 4'd0;
                    SU_X1: x1_next = alu_sum[AW-1] ? xe_reg : AW'(canvas_w_reg);
                    SU_Y1: y1_next = alu_sum[AW-1] ? ye_reg : AW'(canvas_h_reg);
                    SU_NC:
                    begin
                        nc_next     = alu_sum[4:0];
                        nc_pos_next = sum_pos;
                    end
                    SU_NR:
                    begin
                        drawn_next     = nc_pos_reg && sum_pos;
                        rows_left_next = alu_sum[4:0];
                        r_next         = rs_reg;
                        c_next         = cs_reg;
                        cr_next        = y_reg[AW-1] ? '0 : y_reg[CW-1:0];
                        mr_next        = sy_reg;
                        if (undo_en)
                        begin
                            state_next = ST_CK_TEST;
                        end
                        else if (nc_pos_reg && sum_pos)
                        begin
                            state_next = ST_ROW;
                        end
                        else
                        begin
                            state_next = ST_DONE;
                        end
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_CK_TEST:
            begin
                if (ck_in_range)
                begin
                    idx_next   = ck_idx;
                    state_next = ST_CK_CHECK;
                end
                else
                begin
                    ck_step = 1'b1;
                end
            end
            ST_CK_CHECK:
            begin
                ck_step    = 1'b1;
                state_next = ST_CK_TEST;
                if (!ram_rdata[idx_reg[DBW-1:0]])
                begin
                    ram_we                = 1'b1;
                    result_strobe_next    = 1'b1;
                    result_next.item_kind = mbsc_pkg::KIND_UNDO;
                    result_next.chunk_col = c_reg[mbsc_pkg::CHUNK_COORD_W-1:0];
                    result_next.chunk_row = r_reg[mbsc_pkg::CHUNK_COORD_W-1:0];
                    result_next.layer_out = req_reg.layer_index;
                end
            end
            ST_ROW:
            begin
                result_strobe_next     = 1'b1;
                result_next.item_kind  = mbsc_pkg::KIND_ROW;
                result_next.layer_out  = req_reg.layer_index;
                result_next.row_y      = cr_reg;
                result_next.col_start  = x_reg[AW-1] ? '0 : x_reg[CW-1:0];
                result_next.pixel_mask = row_bits & col_mask;
                result_next.color_out  = req_reg.paint_color;
                result_next.refresh    = !req_reg.layer_is_bump;
                cr_next                = cr_reg + 1'b1;
                mr_next                = mr_reg + 1'b1;
                rows_left_next         = rows_left_reg - 1'b1;
                if (rows_left_reg == 5'd1)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                result_strobe_next    = 1'b1;
                result_next.item_kind = mbsc_pkg::KIND_DONE;
                result_next.layer_out = req_reg.layer_index;
                result_next.drawn     = drawn_reg;
                result_next.last      = 1'b1;
                state_next            = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (ck_step)
        begin
            if (c_reg == ce_reg)
            begin
                c_next = cs_reg;
                if (r_reg == re_reg)
                begin
                    state_next = drawn_reg ? ST_ROW : ST_DONE;
                end
                else
                begin
                    r_next = r_reg + 1'b1;
                end
            end
            else
            begin
                c_next = c_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_CLEAR;
            step_reg          <= SU_X;
            clr_cnt_reg       <= '0;
            result_strobe_reg <= 1'b0;
            canvas_w_reg      <= mbsc_pkg::CNV_W'(256);
            canvas_h_reg      <= mbsc_pkg::CNV_W'(256);
            brush_w_reg       <= mbsc_pkg::BRUSH_W'(1);
            brush_h_reg       <= mbsc_pkg::BRUSH_W'(1);
            layer_cnt_reg     <= mbsc_pkg::LCNT_W'(1);
        end
        else
        begin
            state_reg         <= state_next;
            step_reg          <= step_next;
            clr_cnt_reg       <= clr_cnt_next;
            result_strobe_reg <= result_strobe_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    mbsc_pkg::CFG_CANVAS_WIDTH:
                    begin
                        canvas_w_reg <= (cfg_data > mbsc_pkg::CNV_W'(mbsc_pkg::MAX_CANVAS))
                                      ? mbsc_pkg::CNV_W'(mbsc_pkg::MAX_CANVAS) : cfg_data;
                    end
                    mbsc_pkg::CFG_CANVAS_HEIGHT:
                    begin
                        canvas_h_reg <= (cfg_data > mbsc_pkg::CNV_W'(mbsc_pkg::MAX_CANVAS))
                                      ? mbsc_pkg::CNV_W'(mbsc_pkg::MAX_CANVAS) : cfg_data;
                    end
                    mbsc_pkg::CFG_BRUSH_WIDTH:
                    begin
                        brush_w_reg <= (cfg_data[4:0] > mbsc_pkg::BRUSH_W'(mbsc_pkg::MAX_BRUSH))
                                     ? mbsc_pkg::BRUSH_W'(mbsc_pkg::MAX_BRUSH) : cfg_data[4:0];
                    end
                    mbsc_pkg::CFG_BRUSH_HEIGHT:
                    begin
                        brush_h_reg <= (cfg_data[4:0] > mbsc_pkg::BRUSH_W'(mbsc_pkg::MAX_BRUSH))
                                     ? mbsc_pkg::BRUSH_W'(mbsc_pkg::MAX_BRUSH) : cfg_data[4:0];
                    end
                    mbsc_pkg::CFG_LAYER_COUNT:
                    begin
                        layer_cnt_reg <= cfg_data[4:0];
                    end
                    default:
                    begin
                        layer_cnt_reg <= layer_cnt_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (request.req_type == mbsc_pkg::REQ_LOAD))
        begin
            brush_mask_reg[request.mask_row] <= request.mask_bits;
        end
        result_reg    <= result_next;
        req_reg       <= req_next;
        x_reg         <= x_next;
        y_reg         <= y_next;
        xe_reg        <= xe_next;
        ye_reg        <= ye_next;
        x1_reg        <= x1_next;
        y1_reg        <= y1_next;
        cs_reg        <= cs_next;
        ce_reg        <= ce_next;
        rs_reg        <= rs_next;
        re_reg        <= re_next;
        r_reg         <= r_next;
        c_reg         <= c_next;
        sx_reg        <= sx_next;
        sy_reg        <= sy_next;
        nc_reg        <= nc_next;
        nc_pos_reg    <= nc_pos_next;
        drawn_reg     <= drawn_next;
        rows_left_reg <= rows_left_next;
        idx_reg       <= idx_next;
        cr_reg        <= cr_next;
        mr_reg        <= mr_next;
    end

    ap_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && result.last) |-> (state_reg == ST_IDLE))
        else $error("done item without return to idle");

    ap_strobe_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> ($past(state_reg) != ST_IDLE))
        else $error("result strobe from idle");

    ap_row_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROW) |-> (rows_left_reg != '0))
        else $error("row write with no rows left");

    ap_dirty_write: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ((state_reg == ST_CLEAR) || (state_reg == ST_CK_CHECK)))
        else $error("dirty map written outside clear or chunk check");

endmodule

`default_nettype wire
